/* hdl/ptz_pkg.sv */
// ----------------------------------------------------------------------------
// ptz_pkg
// Shared codes for the PTZ command decoder: groups, command bytes, actions.
// ----------------------------------------------------------------------------
package ptz_pkg;

  // result groups
  localparam logic [2:0] GRP_MOTION = 3'd0;
  localparam logic [2:0] GRP_PRESET = 3'd1;
  localparam logic [2:0] GRP_CRUISE = 3'd2;
  localparam logic [2:0] GRP_SCAN   = 3'd3;
  localparam logic [2:0] GRP_RANGE  = 3'd4;

  // command byte codes
  localparam logic [7:0] CMD_STOP        = 8'h00;
  localparam logic [7:0] CMD_RIGHT       = 8'h01;
  localparam logic [7:0] CMD_LEFT        = 8'h02;
  localparam logic [7:0] CMD_DOWN        = 8'h04;
  localparam logic [7:0] CMD_DOWN_RIGHT  = 8'h05;
  localparam logic [7:0] CMD_DOWN_LEFT   = 8'h06;
  localparam logic [7:0] CMD_UP          = 8'h08;
  localparam logic [7:0] CMD_UP_RIGHT    = 8'h09;
  localparam logic [7:0] CMD_UP_LEFT     = 8'h0A;
  localparam logic [7:0] CMD_ZOOM_IN     = 8'h10;
  localparam logic [7:0] CMD_ZOOM_OUT    = 8'h20;
  localparam logic [7:0] CMD_IRIS_STOP   = 8'h40;
  localparam logic [7:0] CMD_FOCUS_FAR   = 8'h41;
  localparam logic [7:0] CMD_FOCUS_NEAR  = 8'h42;
  localparam logic [7:0] CMD_IRIS_OPEN   = 8'h44;
  localparam logic [7:0] CMD_IRIS_CLOSE  = 8'h48;
  localparam logic [7:0] CMD_FAR_CLOSE   = 8'h49;
  localparam logic [7:0] CMD_MOTION_END  = 8'h4A;
  localparam logic [7:0] CMD_PRESET_SET  = 8'h81;
  localparam logic [7:0] CMD_PRESET_CLR  = 8'h83;
  localparam logic [7:0] CMD_CRUISE_ADD  = 8'h84;
  localparam logic [7:0] CMD_CRUISE_DEL  = 8'h85;
  localparam logic [7:0] CMD_CRUISE_SPD  = 8'h86;
  localparam logic [7:0] CMD_CRUISE_DWL  = 8'h87;
  localparam logic [7:0] CMD_CRUISE_RUN  = 8'h88;
  localparam logic [7:0] CMD_SCAN_FIRST  = 8'h89;
  localparam logic [7:0] CMD_SCAN_LAST   = 8'h8A;

  // motion action codes
  localparam logic [3:0] ACT_PAN_RIGHT  = 4'd0;
  localparam logic [3:0] ACT_PAN_LEFT   = 4'd1;
  localparam logic [3:0] ACT_TILT_DOWN  = 4'd2;
  localparam logic [3:0] ACT_TILT_UP    = 4'd3;
  localparam logic [3:0] ACT_DOWN_RIGHT = 4'd4;
  localparam logic [3:0] ACT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] ACT_UP_RIGHT   = 4'd6;
  localparam logic [3:0] ACT_UP_LEFT    = 4'd7;
  localparam logic [3:0] ACT_ZOOM_IN    = 4'd8;
  localparam logic [3:0] ACT_ZOOM_OUT   = 4'd9;
  localparam logic [3:0] ACT_IRIS_CLOSE = 4'd10;
  localparam logic [3:0] ACT_IRIS_OPEN  = 4'd11;
  localparam logic [3:0] ACT_FOCUS_NEAR = 4'd12;
  localparam logic [3:0] ACT_FOCUS_FAR  = 4'd13;

  // full scale of the 12-bit cruise value field
  localparam logic [11:0] CRUISE_FULL = 12'd4095;

  // speed clamp to one through seven
  function automatic logic [2:0] clamp_speed(input logic [7:0] raw);
    logic [2:0] s;
    if (raw > 8'd7) begin
      s = 3'd7;
    end else if (raw == 8'd0) begin
      s = 3'd1;
    end else begin
      s = raw[2:0];
    end
    return s;
  endfunction

endpackage

/* hdl/ptz_command_decoder.sv */
// ----------------------------------------------------------------------------
// ptz_command_decoder
// Decodes one PTZ control command into group, action and parameter fields.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   busy is always low, so a command may be offered in every cycle.
//   The command and its three parameter bytes are captured in an input
//   register; the decode (including the cruise speed/dwell scaling by
//   40/4095 or 255/4095, done as shift-add or shift-subtract and one compare-increment) sits
//   between that register and the result register.
//   done is registered from the input-stage valid flag, beside the result
//   register that takes the decode; done is held for exactly one cycle.
//   Throughput: one command per cycle, set by the single decode stage.
//   Every command gives exactly one result beat. The receiver cannot stall
//   and must take each result in the cycle that done is high.
//   Reset (rst, synchronous) clears the two stage valid flags, so no result
//   beat is produced until a new command is accepted.
// ----------------------------------------------------------------------------
module ptz_command_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] command_byte,
  input  logic [7:0] horizontal_byte,
  input  logic [7:0] vertical_byte,
  input  logic [7:0] zoom_byte,
  output logic       done,
  output logic [2:0] group,
  output logic [3:0] action_code,
  output logic       stop_flag,
  output logic [2:0] speed,
  output logic [7:0] preset_index,
  output logic [7:0] cruise_route,
  output logic [7:0] cruise_point,
  output logic [7:0] cruise_value,
  output logic       known_code
);

  logic       in_valid;
  logic [7:0] cmd;
  logic [7:0] hor;
  logic [7:0] ver;
  logic [7:0] zm;

  logic [2:0] group_next;
  logic [3:0] action_next;
  logic       stop_next;
  logic [2:0] speed_next;
  logic [7:0] preset_next;
  logic [7:0] route_next;
  logic [7:0] point_next;
  logic [7:0] value_next;
  logic       known_next;

  logic [7:0]  raw;
  logic [11:0] v12;
  logic [19:0] prod;
  logic [7:0]  quot_lo;
  logic [12:0] rem;
  logic [7:0]  quot;
  logic [7:0]  scaled;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd <= command_byte;
      hor <= horizontal_byte;
      ver <= vertical_byte;
      zm  <= zoom_byte;
    end
  end

  // cruise value scaling: v12 * k / 4095 with k 40 or 255
  assign v12 = {zm[7:4], ver};

  always_comb begin
    if (cmd == ptz_pkg::CMD_CRUISE_SPD) begin
      prod = ({8'd0, v12} << 5) + ({8'd0, v12} << 3);
    end else begin
      prod = ({8'd0, v12} << 8) - {8'd0, v12};
    end
  end

  // x = q*4096 + lo = q*4095 + (lo + q), remainder stays below twice 4095
  assign quot_lo = prod[19:12];
  assign rem     = {1'b0, prod[11:0]} + {5'd0, quot_lo};
  assign quot    = (rem >= {1'b0, ptz_pkg::CRUISE_FULL}) ? quot_lo + 8'd1 : quot_lo;
  assign scaled  = (quot == 8'd0) ? 8'd1 : quot;

  // command decode
  always_comb begin
    group_next  = ptz_pkg::GRP_RANGE;
    action_next = ptz_pkg::ACT_PAN_RIGHT;
    stop_next   = 1'b0;
    speed_next  = 3'd1;
    preset_next = 8'd0;
    route_next  = 8'd0;
    point_next  = 8'd0;
    value_next  = 8'd0;
    known_next  = 1'b0;
    raw         = 8'd0;

    if (cmd < ptz_pkg::CMD_MOTION_END) begin
      group_next = ptz_pkg::GRP_MOTION;
      known_next = 1'b1;
      unique case (cmd) inside
        ptz_pkg::CMD_STOP: begin
          stop_next = 1'b1;
        end
        ptz_pkg::CMD_RIGHT: begin
          action_next = ptz_pkg::ACT_PAN_RIGHT;
          raw         = hor;
        end
        ptz_pkg::CMD_LEFT: begin
          action_next = ptz_pkg::ACT_PAN_LEFT;
          raw         = hor;
        end
        ptz_pkg::CMD_DOWN: begin
          action_next = ptz_pkg::ACT_TILT_DOWN;
          raw         = ver;
        end
        ptz_pkg::CMD_UP: begin
          action_next = ptz_pkg::ACT_TILT_UP;
          raw         = ver;
        end
        ptz_pkg::CMD_DOWN_RIGHT: begin
          action_next = ptz_pkg::ACT_DOWN_RIGHT;
          raw         = hor;
        end
        ptz_pkg::CMD_DOWN_LEFT: begin
          action_next = ptz_pkg::ACT_DOWN_LEFT;
          raw         = hor;
        end
        ptz_pkg::CMD_UP_RIGHT: begin
          action_next = ptz_pkg::ACT_UP_RIGHT;
          raw         = hor;
        end
        ptz_pkg::CMD_UP_LEFT: begin
          action_next = ptz_pkg::ACT_UP_LEFT;
          raw         = hor;
        end
        ptz_pkg::CMD_ZOOM_IN: begin
          action_next = ptz_pkg::ACT_ZOOM_IN;
          raw         = {4'd0, zm[7:4]};
        end
        ptz_pkg::CMD_ZOOM_OUT: begin
          action_next = ptz_pkg::ACT_ZOOM_OUT;
          raw         = {4'd0, zm[7:4]};
        end
        ptz_pkg::CMD_IRIS_CLOSE: begin
          action_next = ptz_pkg::ACT_IRIS_CLOSE;
          raw         = ver;
        end
        ptz_pkg::CMD_IRIS_OPEN: begin
          action_next = ptz_pkg::ACT_IRIS_OPEN;
          raw         = ver;
        end
        // iris stop reads as iris open at the slowest speed
        ptz_pkg::CMD_IRIS_STOP: begin
          action_next = ptz_pkg::ACT_IRIS_OPEN;
        end
        ptz_pkg::CMD_FOCUS_NEAR: begin
          action_next = ptz_pkg::ACT_FOCUS_NEAR;
          raw         = hor;
        end
        // focus far with iris close is taken as plain focus far
        ptz_pkg::CMD_FOCUS_FAR, ptz_pkg::CMD_FAR_CLOSE: begin
          action_next = ptz_pkg::ACT_FOCUS_FAR;
          raw         = hor;
        end
        default: begin
          known_next = 1'b0;
        end
      endcase
      speed_next = ptz_pkg::clamp_speed(raw);
    end else if (cmd >= ptz_pkg::CMD_PRESET_SET && cmd <= ptz_pkg::CMD_PRESET_CLR) begin
      group_next  = ptz_pkg::GRP_PRESET;
      known_next  = 1'b1;
      action_next = 4'(cmd - ptz_pkg::CMD_PRESET_SET);
      preset_next = ver;
    end else if (cmd >= ptz_pkg::CMD_CRUISE_ADD && cmd <= ptz_pkg::CMD_CRUISE_RUN) begin
      group_next  = ptz_pkg::GRP_CRUISE;
      known_next  = 1'b1;
      action_next = 4'(cmd - ptz_pkg::CMD_CRUISE_ADD);
      route_next  = hor;
      if (cmd == ptz_pkg::CMD_CRUISE_ADD || cmd == ptz_pkg::CMD_CRUISE_DEL) begin
        point_next = ver;
        value_next = ver;
      end else if (cmd == ptz_pkg::CMD_CRUISE_SPD || cmd == ptz_pkg::CMD_CRUISE_DWL) begin
        value_next = scaled;
      end
    end else if (cmd == ptz_pkg::CMD_SCAN_FIRST || cmd == ptz_pkg::CMD_SCAN_LAST) begin
      group_next = ptz_pkg::GRP_SCAN;
      known_next = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      group        <= group_next;
      action_code  <= action_next;
      stop_flag    <= stop_next;
      speed        <= speed_next;
      preset_index <= preset_next;
      cruise_route <= route_next;
      cruise_point <= point_next;
      cruise_value <= value_next;
      known_code   <= known_next;
    end
  end

endmodule

/* tb/sv/ptz_command_decoder_tb.sv */
// ----------------------------------------------------------------------------
// ptz_command_decoder_tb
// Self-checking bench for the PTZ command decoder. Command beats go in through
// start/busy with the data bytes changed on the falling edge. Each one is
// decoded by a behavioural predictor in the bench and queued. Every done beat
// is taken at the rising edge and compared field by field with the oldest
// queued decode. Directed beats cover the edge codes and byte extremes. Random
// traffic mostly uses listed codes and runs with several sender idle rates.
// ----------------------------------------------------------------------------
module ptz_command_decoder_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // codes not named in the package
  localparam logic [7:0] CMD_PRESET_GOTO = 8'h82;
  localparam int unsigned SPEED_SCALE = 40;
  localparam int unsigned DWELL_SCALE = 255;
  localparam int NUM_LISTED = 27;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0] group;
    logic [3:0] action;
    logic       stop;
    logic [2:0] speed;
    logic [7:0] preset;
    logic [7:0] route;
    logic [7:0] point;
    logic [7:0] value;
    logic       known;
  } ptz_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [7:0] command_byte = 8'd0;
  logic [7:0] horizontal_byte = 8'd0;
  logic [7:0] vertical_byte = 8'd0;
  logic [7:0] zoom_byte = 8'd0;
  logic       busy;
  logic       done;
  logic [2:0] group;
  logic [3:0] action_code;
  logic       stop_flag;
  logic [2:0] speed;
  logic [7:0] preset_index;
  logic [7:0] cruise_route;
  logic [7:0] cruise_point;
  logic [7:0] cruise_value;
  logic       known_code;

  ptz_result_t pending_decodes[$];
  int          fault_count = 0;
  int          idle_pct = 0;

  ptz_command_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command_byte   (command_byte),
    .horizontal_byte(horizontal_byte),
    .vertical_byte  (vertical_byte),
    .zoom_byte      (zoom_byte),
    .done           (done),
    .group          (group),
    .action_code    (action_code),
    .stop_flag      (stop_flag),
    .speed          (speed),
    .preset_index   (preset_index),
    .cruise_route   (cruise_route),
    .cruise_point   (cruise_point),
    .cruise_value   (cruise_value),
    .known_code     (known_code)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // behavioural decode of one command
  function automatic ptz_result_t predict_decode(input logic [7:0] cmd, input logic [7:0] hor,
                                                 input logic [7:0] ver, input logic [7:0] zoom);
    ptz_result_t r;
    logic [7:0]  raw;
    logic [11:0] field12;
    int unsigned scaled;
    r = '0;
    r.group = ptz_pkg::GRP_RANGE;
    r.speed = 3'd1;
    raw = 8'd0;
    field12 = {zoom[7:4], ver};
    scaled = 0;
    if (cmd < ptz_pkg::CMD_MOTION_END) begin
      r.group = ptz_pkg::GRP_MOTION;
      r.known = 1'b1;
      case (cmd) inside
        ptz_pkg::CMD_STOP:       r.stop = 1'b1;
        ptz_pkg::CMD_RIGHT:      begin r.action = ptz_pkg::ACT_PAN_RIGHT;  raw = hor; end
        ptz_pkg::CMD_LEFT:       begin r.action = ptz_pkg::ACT_PAN_LEFT;   raw = hor; end
        ptz_pkg::CMD_DOWN:       begin r.action = ptz_pkg::ACT_TILT_DOWN;  raw = ver; end
        ptz_pkg::CMD_UP:         begin r.action = ptz_pkg::ACT_TILT_UP;    raw = ver; end
        ptz_pkg::CMD_DOWN_RIGHT: begin r.action = ptz_pkg::ACT_DOWN_RIGHT; raw = hor; end
        ptz_pkg::CMD_DOWN_LEFT:  begin r.action = ptz_pkg::ACT_DOWN_LEFT;  raw = hor; end
        ptz_pkg::CMD_UP_RIGHT:   begin r.action = ptz_pkg::ACT_UP_RIGHT;   raw = hor; end
        ptz_pkg::CMD_UP_LEFT:    begin r.action = ptz_pkg::ACT_UP_LEFT;    raw = hor; end
        ptz_pkg::CMD_ZOOM_IN: begin
          r.action = ptz_pkg::ACT_ZOOM_IN;
          raw = {4'd0, zoom[7:4]};
        end
        ptz_pkg::CMD_ZOOM_OUT: begin
          r.action = ptz_pkg::ACT_ZOOM_OUT;
          raw = {4'd0, zoom[7:4]};
        end
        ptz_pkg::CMD_IRIS_CLOSE: begin r.action = ptz_pkg::ACT_IRIS_CLOSE; raw = ver; end
        ptz_pkg::CMD_IRIS_OPEN:  begin r.action = ptz_pkg::ACT_IRIS_OPEN;  raw = ver; end
        ptz_pkg::CMD_IRIS_STOP:  r.action = ptz_pkg::ACT_IRIS_OPEN;
        ptz_pkg::CMD_FOCUS_NEAR: begin r.action = ptz_pkg::ACT_FOCUS_NEAR; raw = hor; end
        ptz_pkg::CMD_FOCUS_FAR, ptz_pkg::CMD_FAR_CLOSE: begin
          r.action = ptz_pkg::ACT_FOCUS_FAR;
          raw = hor;
        end
        default:        r.known = 1'b0;
      endcase
      // speed limited to one through seven
      if (raw == 8'd0) begin
        r.speed = 3'd1;
      end else if (raw > 8'd7) begin
        r.speed = 3'd7;
      end else begin
        r.speed = raw[2:0];
      end
    end else if (cmd >= ptz_pkg::CMD_PRESET_SET && cmd <= ptz_pkg::CMD_PRESET_CLR) begin
      r.group = ptz_pkg::GRP_PRESET;
      r.known = 1'b1;
      r.action = 4'(cmd - ptz_pkg::CMD_PRESET_SET);
      r.preset = ver;
    end else if (cmd >= ptz_pkg::CMD_CRUISE_ADD && cmd <= ptz_pkg::CMD_CRUISE_RUN) begin
      r.group = ptz_pkg::GRP_CRUISE;
      r.known = 1'b1;
      r.action = 4'(cmd - ptz_pkg::CMD_CRUISE_ADD);
      r.route = hor;
      case (cmd) inside
        ptz_pkg::CMD_CRUISE_ADD, ptz_pkg::CMD_CRUISE_DEL: begin
          r.point = ver;
          r.value = ver;
        end
        ptz_pkg::CMD_CRUISE_SPD, ptz_pkg::CMD_CRUISE_DWL: begin
          if (cmd == ptz_pkg::CMD_CRUISE_SPD) begin
            scaled = 32'(field12) * SPEED_SCALE / 32'(ptz_pkg::CRUISE_FULL);
          end else begin
            scaled = 32'(field12) * DWELL_SCALE / 32'(ptz_pkg::CRUISE_FULL);
          end
          r.value = (scaled == 0) ? 8'd1 : scaled[7:0];
        end
        default: ;
      endcase
    end else if (cmd == ptz_pkg::CMD_SCAN_FIRST || cmd == ptz_pkg::CMD_SCAN_LAST) begin
      r.group = ptz_pkg::GRP_SCAN;
      r.known = 1'b1;
    end
    return r;
  endfunction

  function automatic string show_result(input ptz_result_t r);
    return $sformatf({"grp=%0d act=%0d stop=%0d spd=%0d pidx=%0d route=%0d ",
                      "point=%0d val=%0d known=%0d"},
                     r.group, r.action, r.stop, r.speed, r.preset, r.route, r.point,
                     r.value, r.known);
  endfunction

  // command codes the block lists, for weighted random picks
  function automatic logic [7:0] listed_code(input int k);
    logic [7:0] c;
    case (k)
      0:  c = ptz_pkg::CMD_STOP;
      1:  c = ptz_pkg::CMD_RIGHT;
      2:  c = ptz_pkg::CMD_LEFT;
      3:  c = ptz_pkg::CMD_DOWN;
      4:  c = ptz_pkg::CMD_DOWN_RIGHT;
      5:  c = ptz_pkg::CMD_DOWN_LEFT;
      6:  c = ptz_pkg::CMD_UP;
      7:  c = ptz_pkg::CMD_UP_RIGHT;
      8:  c = ptz_pkg::CMD_UP_LEFT;
      9:  c = ptz_pkg::CMD_ZOOM_IN;
      10: c = ptz_pkg::CMD_ZOOM_OUT;
      11: c = ptz_pkg::CMD_IRIS_STOP;
      12: c = ptz_pkg::CMD_FOCUS_FAR;
      13: c = ptz_pkg::CMD_FOCUS_NEAR;
      14: c = ptz_pkg::CMD_IRIS_OPEN;
      15: c = ptz_pkg::CMD_IRIS_CLOSE;
      16: c = ptz_pkg::CMD_FAR_CLOSE;
      17: c = ptz_pkg::CMD_PRESET_SET;
      18: c = CMD_PRESET_GOTO;
      19: c = ptz_pkg::CMD_PRESET_CLR;
      20: c = ptz_pkg::CMD_CRUISE_ADD;
      21: c = ptz_pkg::CMD_CRUISE_DEL;
      22: c = ptz_pkg::CMD_CRUISE_SPD;
      23: c = ptz_pkg::CMD_CRUISE_DWL;
      24: c = ptz_pkg::CMD_CRUISE_RUN;
      25: c = ptz_pkg::CMD_SCAN_FIRST;
      default: c = ptz_pkg::CMD_SCAN_LAST;
    endcase
    return c;
  endfunction

  // one command beat, with random idle cycles ahead of it
  task automatic send_command(input logic [7:0] cmd, input logic [7:0] hor,
                              input logic [7:0] ver, input logic [7:0] zoom);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      command_byte <= 8'($urandom);
      horizontal_byte <= 8'($urandom);
      vertical_byte <= 8'($urandom);
      zoom_byte <= 8'($urandom);
    end
    @(negedge clk);
    start <= 1'b1;
    command_byte <= cmd;
    horizontal_byte <= hor;
    vertical_byte <= ver;
    zoom_byte <= zoom;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_decodes.push_back(predict_decode(cmd, hor, ver, zoom));
  endtask

  // motion and lens codes: stop, byte extremes, iris stop, combined focus, unlisted
  task automatic test_motion_codes();
    idle_pct = 0;
    send_command(ptz_pkg::CMD_STOP, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_RIGHT, 8'h00, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_LEFT, 8'hFF, 8'h00, 8'h00);
    send_command(ptz_pkg::CMD_DOWN, 8'h00, 8'h05, 8'h00);
    send_command(ptz_pkg::CMD_ZOOM_IN, 8'hFF, 8'hFF, 8'hF0);
    send_command(ptz_pkg::CMD_ZOOM_OUT, 8'hFF, 8'hFF, 8'h0F);
    send_command(ptz_pkg::CMD_IRIS_STOP, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_FAR_CLOSE, 8'h03, 8'h00, 8'h00);
    send_command(ptz_pkg::CMD_FOCUS_NEAR, 8'h07, 8'h08, 8'h00);
    send_command(ptz_pkg::CMD_STOP + 8'h03, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // preset, cruise scaling ends, scan and out-of-range boundaries
  task automatic test_group_codes();
    idle_pct = 0;
    send_command(ptz_pkg::CMD_PRESET_SET, 8'hFF, 8'h00, 8'hFF);
    send_command(CMD_PRESET_GOTO, 8'h00, 8'hA5, 8'h00);
    send_command(ptz_pkg::CMD_PRESET_CLR, 8'h00, 8'hFF, 8'h00);
    send_command(ptz_pkg::CMD_CRUISE_ADD, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_CRUISE_DEL, 8'h00, 8'h00, 8'h00);
    send_command(ptz_pkg::CMD_CRUISE_SPD, 8'h12, 8'h00, 8'h0F);
    send_command(ptz_pkg::CMD_CRUISE_SPD, 8'h34, 8'hFF, 8'hF0);
    send_command(ptz_pkg::CMD_CRUISE_DWL, 8'h56, 8'h00, 8'h00);
    send_command(ptz_pkg::CMD_CRUISE_DWL, 8'h78, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_CRUISE_RUN, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_SCAN_FIRST, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_SCAN_LAST, 8'h00, 8'h00, 8'h00);
    send_command(ptz_pkg::CMD_MOTION_END, 8'h01, 8'h01, 8'h10);
    send_command(ptz_pkg::CMD_PRESET_SET - 8'h01, 8'hFF, 8'hFF, 8'hFF);
    send_command(ptz_pkg::CMD_SCAN_LAST + 8'h01, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // mostly listed codes, small speeds half the time, rest any byte
  task automatic test_random_traffic(input int count, input int pct);
    logic [7:0] cmd;
    logic [7:0] hor;
    logic [7:0] ver;
    logic [7:0] zoom;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) begin
        cmd = listed_code($urandom_range(NUM_LISTED - 1));
      end else begin
        cmd = 8'($urandom);
      end
      hor = ($urandom_range(1) == 0) ? 8'($urandom_range(9)) : 8'($urandom);
      ver = ($urandom_range(1) == 0) ? 8'($urandom_range(9)) : 8'($urandom);
      zoom = 8'($urandom);
      if ($urandom_range(3) == 0) zoom[7:4] = 4'($urandom_range(1));
      send_command(cmd, hor, ver, zoom);
    end
  endtask

  // compare every done beat with the oldest predicted decode
  always @(posedge clk) begin : result_check
    ptz_result_t got;
    ptz_result_t want;
    if (!rst && done === 1'b1) begin
      got = '{group, action_code, stop_flag, speed, preset_index, cruise_route,
              cruise_point, cruise_value, known_code};
      if (pending_decodes.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("unexpected result beat: %s", show_result(got));
      end else begin
        want = pending_decodes.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("decode mismatch at %0t", $realtime);
            $display("  expected %s", show_result(want));
            $display("  actual   %s", show_result(got));
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_motion_codes();
    test_group_codes();
    test_random_traffic(400, 0);
    test_random_traffic(400, 82);
    test_random_traffic(400, 0);
    test_random_traffic(400, 37);

    @(negedge clk);
    start <= 1'b0;

    // drain, then wait for stray beats
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
